[rtl/core/baram_pkg.sv]
// Shared types and constants for the byte-addressed RAM with access faults.
// Used by the controller, the datapath, the top level and the port checker.
package baram_pkg;

    localparam int LANES    = 8;
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 64;
    localparam int BITS_W   = 7;
    localparam int DATA_W   = 64;
    localparam int SIZE_W   = 17;
    localparam int COUNT_W  = 4;
    localparam int LO_W     = 3;

    // Slave tdata layout, lowest bits first: address, access_bits, store_data, pad.
    localparam int S_ADDR_LSB = 0;
    localparam int S_BITS_LSB = S_ADDR_LSB + ADDR_W;
    localparam int S_DATA_LSB = S_BITS_LSB + BITS_W;
    localparam int S_TDATA_W  = ((S_DATA_LSB + DATA_W + 7) / 8) * 8;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 17'h10000;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_STORE = 1'b1;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_LOAD  = 2'd1,
        FAULT_STORE = 2'd2
    } fault_t;

    // Controller to datapath.
    typedef struct packed {
        logic clear_wr;   // zero one row of every lane
        logic req_load;   // capture the incoming request
        logic check_en;   // evaluate width and window
        logic access_en;  // read or write the lanes
        logic out_load;   // fill the output register
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic clear_last; // clearing pass is on its final row
    } stat_t;

endpackage

[rtl/core/byte_addressed_ram_with_fault.sv]
// Top level of the byte-addressed little-endian RAM with access faults.
// Instantiates baram_ctrl and baram_dp; depends on baram_pkg.
//
// Usage:
//   Requests arrive on the s_* stream. Each transfer is one load or store of
//   8, 16, 32 or 64 bits at any byte alignment. s_tuser is the kind (0 load,
//   1 store). Each request yields exactly one transfer on the m_* stream:
//   m_tdata is the loaded value zero-extended (zero for stores and faults),
//   m_tuser the fault code (0 none, 1 load fault, 2 store fault).
//   A request with an illegal width, or with any byte outside [BASE_ADDRESS,
//   BASE_ADDRESS + effective size), faults and leaves memory untouched. The
//   effective size is the last cfg_data value written, saturated to MEM_BYTES;
//   the user must write it only while the block is idle; it is not enforced.
//
// Timing:
//   The result is presented after the request passes the window check, the
//   lane access and the result format steps in turn. The single request
//   register and the registered bank reads set this order; one request is
//   worked at a time and s_tready returns as the format step fills the
//   output register, with the result presented in the same cycle.
//   The output register decouples the two sides: a new request is taken
//   while an earlier result still waits for m_tready. A stalled receiver
//   holds the next result in the format step until the register drains.
//
// Reset:
//   rst_n clears control and sets the size to 65536. A clearing pass then
//   zeroes one row of all eight byte lanes per cycle, covering
//   ceil(MEM_BYTES / 8) rows (8192 by default); s_tready stays low until
//   it ends. Configuration writes are taken during the pass.
module byte_addressed_ram_with_fault #(
    parameter int          MEM_BYTES    = 65536,
    parameter logic [63:0] BASE_ADDRESS = 64'h0000_0000_8000_0000
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Request stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [63:0] address, [70:64] access_bits, [134:71] store_data, [135] zero
    input  logic [baram_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] kind
    input  logic                               s_tuser,
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [63:0] read_data
    output logic [baram_pkg::DATA_W-1:0]       m_tdata,
    // [1:0] fault
    output logic [1:0]                         m_tuser,
    // Size configuration
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [baram_pkg::SIZE_W-1:0]       cfg_data
);
    import baram_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequence each request through check, access and format.
    baram_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Hold the request, the byte lanes and the result register.
    baram_dp #(
        .MEM_BYTES    (MEM_BYTES),
        .BASE_ADDRESS (BASE_ADDRESS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[rtl/core/baram_ctrl.sv]
// Sequencing state machine for the byte-addressed RAM: clearing pass,
// request capture, check, access and result hand-off. Depends on baram_pkg.
module baram_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output baram_pkg::cmd_t  cmd,
    input  baram_pkg::stat_t stat
);
    import baram_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_ACCESS,
        ST_FORMAT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_tready_reg;
    logic   s_tready_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid && s_tready_reg)
                begin
                    cmd.req_load = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check_en = 1'b1;
                state_next   = ST_ACCESS;
            end
            ST_ACCESS:
            begin
                cmd.access_en = 1'b1;
                state_next    = ST_FORMAT;
            end
            ST_FORMAT:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end

        s_tready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            s_tready_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

[rtl/core/baram_dp.sv]
// Datapath of the byte-addressed RAM: request registers, window check,
// eight byte-lane memory banks, load assembly and output register.
// Depends on baram_pkg; driven by baram_ctrl commands.
module baram_dp #(
    parameter int          MEM_BYTES    = 65536,
    parameter logic [63:0] BASE_ADDRESS = 64'h0000_0000_8000_0000
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  baram_pkg::cmd_t                     cmd,
    output baram_pkg::stat_t                    stat,
    input  logic [baram_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [baram_pkg::SIZE_W-1:0]        cfg_data,
    output logic [baram_pkg::DATA_W-1:0]        m_tdata,
    output logic [1:0]                          m_tuser
);
    import baram_pkg::*;

    localparam int SPAN_W = $clog2(MEM_BYTES + 1);
    localparam int CMP_W  = (SPAN_W > SIZE_W) ? SPAN_W : SIZE_W;
    localparam int ROWS   = (MEM_BYTES + LANES - 1) / LANES;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [CMP_W-1:0] MEM_LIM  = CMP_W'(MEM_BYTES);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    // Configuration
    logic [SIZE_W-1:0] size_reg;

    // Captured request
    logic              kind_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [BITS_W-1:0] bits_reg;
    logic [DATA_W-1:0] data_reg;

    // Check results
    logic               ok_reg;
    logic [SPAN_W-1:0]  off_reg;
    logic [COUNT_W-1:0] count_reg;

    // Clearing pass
    logic [ROW_W-1:0] clear_row_reg;

    // Output register
    logic [DATA_W-1:0] out_data_reg;
    fault_t            out_fault_reg;

    // Check logic
    logic               width_ok;
    logic               below_base;
    logic [ADDR_W-1:0]  diff;
    logic [CMP_W-1:0]   size_ext;
    logic [SPAN_W-1:0]  span;
    logic [SPAN_W-1:0]  off_small;
    logic [SPAN_W:0]    end_off;
    logic               in_window;
    logic [COUNT_W-1:0] count_in;

    logic [LO_W-1:0]   lo;
    logic [ROW_W-1:0]  row_lo;
    logic [ROW_W-1:0]  row_hi;
    logic [BYTE_W-1:0] rd_lane [LANES];
    logic [DATA_W-1:0] load_value;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_ok   = (bits_reg == 7'd8) || (bits_reg == 7'd16) ||
                     (bits_reg == 7'd32) || (bits_reg == 7'd64);
        count_in   = bits_reg[BITS_W-1:3];
        below_base = addr_reg < BASE_ADDRESS;
        diff       = addr_reg - BASE_ADDRESS;
        size_ext   = CMP_W'(size_reg);
        span       = SPAN_W'((size_ext > MEM_LIM) ? MEM_LIM : size_ext);
        off_small  = diff[SPAN_W-1:0];
        end_off    = {1'b0, off_small} + (SPAN_W + 1)'(count_in);
        in_window  = !below_base && ((diff >> SPAN_W) == '0) &&
                     (off_small < span) && (end_off <= {1'b0, span});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_RESET;
            clear_row_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= cfg_data;
            end
            if (cmd.clear_wr)
            begin
                clear_row_reg <= clear_row_reg + ROW_W'(1);
            end
        end
    end

    assign stat.clear_last = (clear_row_reg == LAST_ROW);

    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            kind_reg <= s_tuser;
            addr_reg <= s_tdata[S_ADDR_LSB +: ADDR_W];
            bits_reg <= s_tdata[S_BITS_LSB +: BITS_W];
            data_reg <= s_tdata[S_DATA_LSB +: DATA_W];
        end
        if (cmd.check_en)
        begin
            ok_reg    <= width_ok && in_window;
            off_reg   <= off_small;
            count_reg <= count_in;
        end
        if (cmd.out_load)
        begin
            out_data_reg  <= (ok_reg && (kind_reg == KIND_LOAD)) ? load_value : '0;
            out_fault_reg <= ok_reg ? FAULT_NONE :
                             ((kind_reg == KIND_STORE) ? FAULT_STORE : FAULT_LOAD);
        end
    end

    assign lo     = off_reg[LO_W-1:0];
    assign row_lo = ROW_W'(off_reg >> LO_W);
    assign row_hi = row_lo + ROW_W'(1);

    // Lane b holds every byte whose offset from BASE_ADDRESS is b modulo eight;
    // an unaligned access spills into the next row for lanes below the start lane.
    for (genvar b = 0; b < LANES; b++)
    begin : g_lane
        logic [BYTE_W-1:0] lane_mem [ROWS];
        logic [BYTE_W-1:0] rd_byte_reg;
        logic [LO_W-1:0]   lane_pos;
        logic [ROW_W-1:0]  lane_row;
        logic [ROW_W-1:0]  wr_row;
        logic [BYTE_W-1:0] wr_byte;
        logic              lane_we;
        logic              lane_re;

        always_comb
        begin
            lane_pos = LO_W'(b) - lo;
            lane_row = (LO_W'(b) < lo) ? row_hi : row_lo;
            lane_re  = cmd.access_en && ok_reg && (kind_reg == KIND_LOAD);
            lane_we  = cmd.clear_wr ||
                       (cmd.access_en && ok_reg && (kind_reg == KIND_STORE) &&
                        ({1'b0, lane_pos} < count_reg));
            wr_row   = cmd.clear_wr ? clear_row_reg : lane_row;
            wr_byte  = cmd.clear_wr ? '0 : data_reg[{lane_pos, 3'b000} +: BYTE_W];
        end

        always_ff @(posedge clk)
        begin
            if (lane_we)
            begin
                lane_mem[wr_row] <= wr_byte;
            end
            if (lane_re)
            begin
                rd_byte_reg <= lane_mem[lane_row];
            end
        end

        assign rd_lane[b] = rd_byte_reg;
    end

    // Rotate lanes back into access order and drop bytes past the width.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            load_value[i*BYTE_W +: BYTE_W] =
                (COUNT_W'(i) < count_reg) ? rd_lane[LO_W'(lo + LO_W'(i))] : '0;
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_fault_reg;

endmodule

[rtl/core/baram_chk.sv]
// Port-level checker for byte_addressed_ram_with_fault, bound to the top.
// Depends on baram_pkg.
module baram_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [baram_pkg::DATA_W-1:0] m_tdata,
    input logic [1:0]                   m_tuser
);
    import baram_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A faulted request returns no data.
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != FAULT_NONE) |-> m_tdata == '0)
        else $error("faulted result carries data");

    // Fault code is one of the three defined values.
    a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == FAULT_NONE) || (m_tuser == FAULT_LOAD) ||
                     (m_tuser == FAULT_STORE))
        else $error("undefined fault code");

    // One request at a time: a transfer drops ready for the next cycle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while one is in flight");

endmodule

bind byte_addressed_ram_with_fault baram_chk u_baram_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[sim/tb.sv]
// Self-checking testbench for byte_addressed_ram_with_fault: random and directed loads and
// stores on the request stream, checked against an in-bench memory image and window model.
// Depends on baram_pkg and the RTL top level only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import baram_pkg::*;

    localparam int          MEM_BYTES    = 65536;
    localparam logic [63:0] BASE_ADDRESS = 64'h0000_0000_8000_0000;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          NUM_PHASES   = 9;

    typedef struct packed {
        logic        kind;
        logic [63:0] address;
        logic [6:0]  access_bits;
        logic [63:0] store_data;
    } mem_req_t;

    typedef struct packed {
        logic [63:0] read_data;
        fault_t      fault;
    } mem_resp_t;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tuser     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b1;
    logic [DATA_W-1:0]    m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [SIZE_W-1:0]    cfg_data    = '0;

    // Bench copy of the memory contents and of the size register.
    logic [7:0]           mem_image [MEM_BYTES];
    logic [SIZE_W-1:0]    size_reg    = SIZE_RESET;

    mem_req_t             pending_reqs [$];
    mem_resp_t            expected_resps [$];
    mem_req_t             cur_req;
    mem_resp_t            want_resp;
    mem_resp_t            got_resp;

    int                   error_count  = 0;
    int                   cycle_count  = 0;
    int                   send_gap     = 0;
    int                   recv_stall   = 0;
    bit                   send_quiet   = 1'b0;
    bit                   recv_quiet   = 1'b0;
    int                   load_ok      = 0;
    int                   store_ok     = 0;
    int                   fault_count  = 0;
    int                   resp_count   = 0;

    byte_addressed_ram_with_fault #(
        .MEM_BYTES    (MEM_BYTES),
        .BASE_ADDRESS (BASE_ADDRESS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < MEM_BYTES; i++)
            mem_image[i] = 8'h00;
    end

    // Apply one request to the memory image and return the response it must produce.
    // A request faults on an illegal width or when any byte lies outside
    // [BASE_ADDRESS, BASE_ADDRESS + span); the span is the size saturated to MEM_BYTES.
    function automatic mem_resp_t apply_access(mem_req_t req);
        mem_resp_t   resp;
        logic [63:0] span;
        logic [63:0] offset;
        logic [63:0] nbytes;
        bit          legal;
        resp.read_data = '0;
        resp.fault     = (req.kind == KIND_STORE) ? FAULT_STORE : FAULT_LOAD;
        case (req.access_bits)
            7'd8, 7'd16, 7'd32, 7'd64: legal = 1'b1;
            default:                   legal = 1'b0;
        endcase
        nbytes = 64'(req.access_bits) / 8;
        span   = (size_reg > MEM_BYTES) ? 64'(MEM_BYTES) : 64'(size_reg);
        if (!legal || req.address < BASE_ADDRESS)
            return resp;
        offset = req.address - BASE_ADDRESS;
        // Compare against the remaining room so that a window near the top cannot wrap.
        if (offset >= span || nbytes > span - offset)
            return resp;
        for (int i = 0; i < 8; i++)
        begin
            if (i < nbytes)
            begin
                if (req.kind == KIND_STORE)
                    mem_image[offset + i] = req.store_data[8*i +: 8];
                else
                    resp.read_data[8*i +: 8] = mem_image[offset + i];
            end
        end
        resp.fault = FAULT_NONE;
        return resp;
    endfunction

    function automatic mem_req_t build_req(logic kind, logic [63:0] address, logic [6:0] nbits,
                                           logic [63:0] data);
        mem_req_t req;
        req.kind        = kind;
        req.address     = address;
        req.access_bits = nbits;
        req.store_data  = data;
        return req;
    endfunction

    // Draw a random request, mostly inside or at the edges of a window of the given span.
    function automatic mem_req_t random_req(logic [63:0] span);
        mem_req_t    req;
        logic [63:0] offset;
        int          pick;
        req.kind       = 1'($urandom_range(0, 1));
        req.store_data = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            // Hot region: keep loads landing on bytes that earlier stores wrote.
            if (span <= 256)
                offset = 64'($urandom_range(0, 32'(span) + 1));
            else
                offset = 64'($urandom_range(0, 255));
            req.address = BASE_ADDRESS + offset;
        end
        else if (pick < 70)
            req.address = BASE_ADDRESS + (64'($urandom) % (span + 8));
        else if (pick < 82)
            req.address = BASE_ADDRESS + span - 64'($urandom_range(0, 9));
        else if (pick < 88)
            req.address = BASE_ADDRESS - 64'($urandom_range(1, 8));
        else if (pick < 95)
            req.address = {$urandom, $urandom};
        else
            req.address = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < 88)
        begin
            case ($urandom_range(0, 3))
                0:       req.access_bits = 7'd8;
                1:       req.access_bits = 7'd16;
                2:       req.access_bits = 7'd32;
                default: req.access_bits = 7'd64;
            endcase
        end
        else
            req.access_bits = 7'($urandom_range(0, 64));
        return req;
    endfunction

    // Sender gap after a transfer: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Request driver: hold an offered request until accepted, then advance to the next one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_resps.push_back(apply_access(cur_req));
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    s_tdata  <= {1'b0, cur_req.store_data, cur_req.access_bits, cur_req.address};
                    s_tuser  <= cur_req.kind;
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 49) == 0)
                        send_quiet <= ~send_quiet;
                    send_gap <= send_quiet ? 0 : pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Response monitor: check every response transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got_resp.read_data = m_tdata;
                got_resp.fault     = fault_t'(m_tuser);
                resp_count++;
                if (expected_resps.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected response data %h fault %0d", $time,
                             got_resp.read_data, got_resp.fault);
                end
                else
                begin
                    want_resp = expected_resps.pop_front();
                    if (got_resp.read_data !== want_resp.read_data)
                    begin
                        error_count++;
                        $display("%0t: read_data mismatch, expected %h actual %h", $time,
                                 want_resp.read_data, got_resp.read_data);
                    end
                    if (got_resp.fault !== want_resp.fault)
                    begin
                        error_count++;
                        $display("%0t: fault mismatch, expected %0d actual %0d", $time,
                                 want_resp.fault, got_resp.fault);
                    end
                    if (want_resp.fault != FAULT_NONE)
                        fault_count++;
                end
            end
            // Drop m_tready for a random stall, with stall-free stretches now and then.
            if ($urandom_range(0, 199) == 0)
                recv_quiet <= ~recv_quiet;
            if (recv_stall > 0)
            begin
                recv_stall <= recv_stall - 1;
                m_tready   <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!recv_quiet)
                begin
                    if ($urandom_range(0, 99) < 20)
                        recv_stall <= $urandom_range(1, 3);
                    else if ($urandom_range(0, 99) < 3)
                        recv_stall <= $urandom_range(10, 40);
                end
            end
        end
    end

    // Count accepted requests by kind for the summary; s_tuser still holds the
    // kind of the transfer taken at this edge.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            if (s_tuser == KIND_STORE)
                store_ok <= store_ok + 1;
            else
                load_ok <= load_ok + 1;
        end
    end

    // Watchdog: end the run as failed once the cycle count reaches CYCLE_LIMIT.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d responses outstanding", $time,
                     expected_resps.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Wait, sampling at the falling edge, until nothing is queued, offered or expected.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_resps.size() != 0);
    endtask

    // Write the size register and mirror it once the transfer completes.
    task automatic write_size(input logic [SIZE_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_reg   = value;
    endtask

    // Phases: one size setting each, the extremes among them, with a full drain in between.
    initial
    begin
        logic [SIZE_W-1:0] phase_size [NUM_PHASES];
        int                phase_items [NUM_PHASES];
        logic [63:0]       span;
        phase_size  = '{17'd65536, 17'd1, 17'd0, 17'd131071, 17'd8, 17'd65537, 17'd0,
                        17'd100, 17'd65536};
        phase_items = '{300, 40, 30, 150, 60, 100, 150, 80, 140};
        phase_size[6] = SIZE_W'($urandom_range(2, 65535));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
                wait_idle();
            write_size(phase_size[p]);
            span = (phase_size[p] > MEM_BYTES) ? 64'(MEM_BYTES) : 64'(phase_size[p]);
            @(negedge clk);
            if (p == 0)
            begin
                // Directed: full-width extremes, misaligned lanes, window edges,
                // wrap at the top of the address space and illegal widths.
                pending_reqs.push_back(build_req(KIND_STORE, BASE_ADDRESS, 7'd64, '1));
                pending_reqs.push_back(build_req(KIND_LOAD, BASE_ADDRESS, 7'd64, '0));
                pending_reqs.push_back(build_req(KIND_STORE, BASE_ADDRESS + 3, 7'd32,
                                                 64'h0123_4567_DEAD_BEEF));
                pending_reqs.push_back(build_req(KIND_LOAD, BASE_ADDRESS + 1, 7'd64, '1));
                pending_reqs.push_back(build_req(KIND_LOAD, BASE_ADDRESS + 4, 7'd16, '0));
                pending_reqs.push_back(build_req(KIND_STORE, BASE_ADDRESS + 65535, 7'd8,
                                                 64'hFFFF_0000_5A5A_00A5));
                pending_reqs.push_back(build_req(KIND_LOAD, BASE_ADDRESS + 65535, 7'd8, '0));
                pending_reqs.push_back(build_req(KIND_STORE, BASE_ADDRESS + 65535, 7'd16, '1));
                pending_reqs.push_back(build_req(KIND_STORE, BASE_ADDRESS + 65528, 7'd64,
                                                 64'h8877_6655_4433_2211));
                pending_reqs.push_back(build_req(KIND_LOAD, BASE_ADDRESS + 65528, 7'd64, '0));
                pending_reqs.push_back(build_req(KIND_LOAD, BASE_ADDRESS + 65529, 7'd64, '0));
                pending_reqs.push_back(build_req(KIND_LOAD, BASE_ADDRESS + 65532, 7'd32, '0));
                pending_reqs.push_back(build_req(KIND_LOAD, BASE_ADDRESS - 1, 7'd8, '0));
                pending_reqs.push_back(build_req(KIND_STORE, 64'h0, 7'd8, '1));
                pending_reqs.push_back(build_req(KIND_LOAD, '1, 7'd64, '0));
                pending_reqs.push_back(build_req(KIND_STORE, 64'hFFFF_FFFF_FFFF_FFF8, 7'd64,
                                                 '1));
                pending_reqs.push_back(build_req(KIND_LOAD, BASE_ADDRESS, 7'd0, '0));
                pending_reqs.push_back(build_req(KIND_STORE, BASE_ADDRESS, 7'd7, '1));
                pending_reqs.push_back(build_req(KIND_LOAD, BASE_ADDRESS, 7'd24, '0));
                pending_reqs.push_back(build_req(KIND_STORE, BASE_ADDRESS, 7'd63, '1));
                pending_reqs.push_back(build_req(KIND_LOAD, BASE_ADDRESS, 7'd1, '0));
                pending_reqs.push_back(build_req(KIND_STORE, BASE_ADDRESS + 256, 7'd16, '0));
                pending_reqs.push_back(build_req(KIND_LOAD, BASE_ADDRESS + 254, 7'd32, '0));
                pending_reqs.push_back(build_req(KIND_LOAD, BASE_ADDRESS, 7'd64, '0));
            end
            for (int n = 0; n < phase_items[p]; n++)
                pending_reqs.push_back(random_req(span));
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d responses over %0d size settings (zero, one and oversized)",
                 resp_count, NUM_PHASES);
        $display("  %0d loads, %0d stores accepted; %0d of them faulted", load_ok, store_ok,
                 fault_count);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/baram_pkg.sv
rtl/core/baram_ctrl.sv
rtl/core/baram_dp.sv
rtl/core/byte_addressed_ram_with_fault.sv
rtl/core/baram_chk.sv
sim/tb.sv
